// ----- rtl/gmc_pkg.sv -----
// Shared types and constants for the gate motor controller.
package gmc_pkg;

  localparam int unsigned TIME_W = 32;
  localparam logic [TIME_W-1:0] THRESHOLD_RESET = 32'd1000;

  typedef enum logic [3:0] {
    ACT_DO_PRESS      = 4'd0,
    ACT_DO_RELEASE    = 4'd1,
    ACT_DC_PRESS      = 4'd2,
    ACT_DC_RELEASE    = 4'd3,
    ACT_SO_PRESS      = 4'd4,
    ACT_SO_RELEASE    = 4'd5,
    ACT_SC_PRESS      = 4'd6,
    ACT_SC_RELEASE    = 4'd7,
    ACT_OPEN_LIMIT    = 4'd8,
    ACT_CLOSED_LIMIT  = 4'd9,
    ACT_OBSTACLE      = 4'd10,
    ACT_CONFLICT      = 4'd11,
    ACT_REVERSE_DONE  = 4'd12
  } action_t;

  typedef enum logic [2:0] {
    PH_CLOSED    = 3'd0,
    PH_OPEN      = 3'd1,
    PH_OPENING   = 3'd2,
    PH_CLOSING   = 3'd3,
    PH_REVERSING = 3'd4,
    PH_STOPPED   = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    MD_NONE   = 2'd0,
    MD_MANUAL = 2'd1,
    MD_AUTO   = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    CM_NONE  = 2'd0,
    CM_OPEN  = 2'd1,
    CM_CLOSE = 2'd2,
    CM_STOP  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    OR_NONE     = 2'd0,
    OR_DRIVER   = 2'd1,
    OR_SECURITY = 2'd2,
    OR_SAFETY   = 2'd3
  } origin_t;

  typedef enum logic [1:0] {
    MOT_STOP  = 2'd0,
    MOT_OPEN  = 2'd1,
    MOT_CLOSE = 2'd2
  } motor_t;

  // held button bit positions
  localparam int unsigned HB_DO = 0;
  localparam int unsigned HB_DC = 1;
  localparam int unsigned HB_SO = 2;
  localparam int unsigned HB_SC = 3;

  typedef struct packed {
    phase_t            phase;
    mode_t             mode;
    cmd_t              cmd;
    origin_t           origin;
    logic [3:0]        held;
    cmd_t              lp_cmd;
    origin_t           lp_origin;
    logic [TIME_W-1:0] lp_time;
  } gmc_state_t;

  localparam gmc_state_t STATE_RESET = '{
    phase:     PH_CLOSED,
    mode:      MD_NONE,
    cmd:       CM_NONE,
    origin:    OR_NONE,
    held:      4'b0000,
    lp_cmd:    CM_NONE,
    lp_origin: OR_NONE,
    lp_time:   '0
  };

endpackage

// ----- rtl/gmc_ifs.sv -----
// Channel interfaces: event input, status result and threshold write.
interface gmc_evt_if;
  logic        valid;
  logic        ready;
  logic [3:0]  action;
  logic [31:0] time_ms;
  modport source (output valid, output action, output time_ms, input ready);
  modport sink (input valid, input action, input time_ms, output ready);
endinterface

interface gmc_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] gate_status;
  logic [1:0] mode_out;
  logic [1:0] command_out;
  logic [1:0] motor_drive;
  modport source (output valid, output gate_status, output mode_out,
                  output command_out, output motor_drive, input ready);
  modport sink (input valid, input gate_status, input mode_out,
                input command_out, input motor_drive, output ready);
endinterface

interface gmc_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] press_limit_ms;
  modport source (output valid, output press_limit_ms, input ready);
  modport sink (input valid, input press_limit_ms, output ready);
endinterface

// ----- rtl/gmc_next.sv -----
// Next-state logic of the gate controller for one event.
module gmc_next (
  input  gmc_pkg::gmc_state_t  state,
  input  gmc_pkg::action_t     action,
  input  logic [31:0]          time_ms,
  input  logic [31:0]          threshold,
  output gmc_pkg::gmc_state_t  state_next
);

  typedef struct packed {
    gmc_pkg::cmd_t    cmd;
    gmc_pkg::origin_t origin;
  } pick_t;

  function automatic gmc_pkg::gmc_state_t stop_f(gmc_pkg::gmc_state_t s);
    gmc_pkg::gmc_state_t r;
    r = s;
    r.phase  = gmc_pkg::PH_STOPPED;
    r.mode   = gmc_pkg::MD_NONE;
    r.cmd    = gmc_pkg::CM_STOP;
    r.origin = gmc_pkg::OR_NONE;
    return r;
  endfunction

  function automatic gmc_pkg::gmc_state_t open_f(gmc_pkg::gmc_state_t s,
                                                 gmc_pkg::origin_t o);
    gmc_pkg::gmc_state_t r;
    r = s;
    if (s.phase != gmc_pkg::PH_OPEN) begin
      r.phase  = gmc_pkg::PH_OPENING;
      r.mode   = gmc_pkg::MD_MANUAL;
      r.cmd    = gmc_pkg::CM_OPEN;
      r.origin = o;
    end
    return r;
  endfunction

  function automatic gmc_pkg::gmc_state_t close_f(gmc_pkg::gmc_state_t s,
                                                  gmc_pkg::origin_t o);
    gmc_pkg::gmc_state_t r;
    r = s;
    if (s.phase != gmc_pkg::PH_CLOSED) begin
      r.phase  = gmc_pkg::PH_CLOSING;
      r.mode   = gmc_pkg::MD_MANUAL;
      r.cmd    = gmc_pkg::CM_CLOSE;
      r.origin = o;
    end
    return r;
  endfunction

  // security outranks driver; a panel with both buttons held gives nothing
  function automatic pick_t pick_f(logic [3:0] h);
    pick_t p;
    p.cmd    = gmc_pkg::CM_NONE;
    p.origin = gmc_pkg::OR_NONE;
    if (h[gmc_pkg::HB_SO] && !h[gmc_pkg::HB_SC]) begin
      p.cmd    = gmc_pkg::CM_OPEN;
      p.origin = gmc_pkg::OR_SECURITY;
    end else if (h[gmc_pkg::HB_SC] && !h[gmc_pkg::HB_SO]) begin
      p.cmd    = gmc_pkg::CM_CLOSE;
      p.origin = gmc_pkg::OR_SECURITY;
    end else if (h[gmc_pkg::HB_DO] && !h[gmc_pkg::HB_DC]) begin
      p.cmd    = gmc_pkg::CM_OPEN;
      p.origin = gmc_pkg::OR_DRIVER;
    end else if (h[gmc_pkg::HB_DC] && !h[gmc_pkg::HB_DO]) begin
      p.cmd    = gmc_pkg::CM_CLOSE;
      p.origin = gmc_pkg::OR_DRIVER;
    end
    return p;
  endfunction

  function automatic gmc_pkg::gmc_state_t eval_f(gmc_pkg::gmc_state_t s);
    pick_t p;
    gmc_pkg::gmc_state_t r;
    p = pick_f(s.held);
    r = s;
    if (s.mode == gmc_pkg::MD_AUTO && s.origin == gmc_pkg::OR_SECURITY &&
        !s.held[gmc_pkg::HB_SO] && !s.held[gmc_pkg::HB_SC]) begin
      r = s;
    end else if ((s.held[gmc_pkg::HB_SO] && s.held[gmc_pkg::HB_SC]) ||
                 (s.held[gmc_pkg::HB_DO] && s.held[gmc_pkg::HB_DC])) begin
      r = stop_f(s);
    end else if (p.cmd == gmc_pkg::CM_OPEN) begin
      r = open_f(s, p.origin);
    end else if (p.cmd == gmc_pkg::CM_CLOSE) begin
      r = close_f(s, p.origin);
    end
    return r;
  endfunction

  logic [31:0]         dur;
  logic [3:0]          btn;
  gmc_pkg::cmd_t       btn_cmd;
  gmc_pkg::origin_t    btn_origin;
  pick_t               rest;
  gmc_pkg::gmc_state_t rel;

  assign dur        = (time_ms < state.lp_time) ? '0 : time_ms - state.lp_time;
  assign btn        = 4'b0001 << action[2:1];
  assign btn_cmd    = action[1] ? gmc_pkg::CM_CLOSE : gmc_pkg::CM_OPEN;
  assign btn_origin = action[2] ? gmc_pkg::OR_SECURITY : gmc_pkg::OR_DRIVER;

  always_comb begin
    rel      = state;
    rel.held = state.held & ~btn;
    rest     = pick_f(rel.held);
  end

  always_comb begin
    state_next = state;
    case (action)
      gmc_pkg::ACT_DO_PRESS, gmc_pkg::ACT_DC_PRESS,
      gmc_pkg::ACT_SO_PRESS, gmc_pkg::ACT_SC_PRESS: begin
        state_next.held      = state.held | btn;
        state_next.lp_cmd    = btn_cmd;
        state_next.lp_origin = btn_origin;
        state_next.lp_time   = time_ms;
        state_next           = eval_f(state_next);
      end
      gmc_pkg::ACT_DO_RELEASE, gmc_pkg::ACT_DC_RELEASE,
      gmc_pkg::ACT_SO_RELEASE, gmc_pkg::ACT_SC_RELEASE: begin
        if (state.lp_cmd != btn_cmd || state.lp_origin != btn_origin) begin
          state_next = eval_f(rel);
        end else if (dur < threshold) begin
          state_next        = rel;
          state_next.mode   = gmc_pkg::MD_AUTO;
          state_next.cmd    = btn_cmd;
          state_next.origin = btn_origin;
        end else if (rest.cmd == gmc_pkg::CM_OPEN || rest.cmd == gmc_pkg::CM_CLOSE) begin
          if (rest.cmd == gmc_pkg::CM_OPEN) begin
            state_next = open_f(rel, rest.origin);
          end else begin
            state_next = close_f(rel, rest.origin);
          end
          state_next.lp_cmd    = rest.cmd;
          state_next.lp_origin = rest.origin;
          state_next.lp_time   = time_ms;
        end else begin
          state_next           = stop_f(rel);
          state_next.lp_cmd    = gmc_pkg::CM_NONE;
          state_next.lp_origin = gmc_pkg::OR_NONE;
        end
      end
      gmc_pkg::ACT_OPEN_LIMIT: begin
        if (state.phase == gmc_pkg::PH_OPENING || state.phase == gmc_pkg::PH_REVERSING) begin
          state_next.phase     = gmc_pkg::PH_OPEN;
          state_next.mode      = gmc_pkg::MD_NONE;
          state_next.cmd       = gmc_pkg::CM_NONE;
          state_next.origin    = gmc_pkg::OR_NONE;
          state_next.lp_cmd    = gmc_pkg::CM_NONE;
          state_next.lp_origin = gmc_pkg::OR_NONE;
        end
      end
      gmc_pkg::ACT_CLOSED_LIMIT: begin
        if (state.phase == gmc_pkg::PH_CLOSING) begin
          state_next.phase     = gmc_pkg::PH_CLOSED;
          state_next.mode      = gmc_pkg::MD_NONE;
          state_next.cmd       = gmc_pkg::CM_NONE;
          state_next.origin    = gmc_pkg::OR_NONE;
          state_next.lp_cmd    = gmc_pkg::CM_NONE;
          state_next.lp_origin = gmc_pkg::OR_NONE;
        end
      end
      gmc_pkg::ACT_OBSTACLE: begin
        if (state.phase == gmc_pkg::PH_CLOSING) begin
          state_next.phase  = gmc_pkg::PH_REVERSING;
          state_next.mode   = gmc_pkg::MD_AUTO;
          state_next.cmd    = gmc_pkg::CM_OPEN;
          state_next.origin = gmc_pkg::OR_SAFETY;
        end
      end
      gmc_pkg::ACT_CONFLICT: begin
        state_next = stop_f(state);
      end
      gmc_pkg::ACT_REVERSE_DONE: begin
        if (state.phase == gmc_pkg::PH_REVERSING) begin
          state_next           = stop_f(state);
          state_next.lp_cmd    = gmc_pkg::CM_NONE;
          state_next.lp_origin = gmc_pkg::OR_NONE;
        end
      end
      default: begin
        state_next = state;
      end
    endcase
  end

endmodule

// ----- rtl/gate_motor_controller_fsm.sv -----
// Gate motor controller top level: event register, next-state logic, result register.
// Two register stages: the event register holds an accepted event, the result register its result.
// Throughput: one event per cycle, save for the stall below; the gate state loop has one register.
// The event and result registers stall only while a result waits to be taken.
// Reset (rst, synchronous): gate idle closed, no mode or command, no buttons held,
// threshold 1000 ms, both pipeline registers empty. Threshold writes are always ready.
module gate_motor_controller_fsm (
  input  logic      clk,
  input  logic      rst,
  gmc_evt_if.sink   evt,
  gmc_res_if.source res,
  gmc_cfg_if.sink   cfg
);

  logic                in_valid;
  gmc_pkg::action_t    in_action;
  logic [31:0]         in_time;
  logic [31:0]         threshold;
  gmc_pkg::gmc_state_t state;
  gmc_pkg::gmc_state_t state_next;
  gmc_pkg::motor_t     motor_next;
  logic                out_valid;
  gmc_pkg::phase_t     out_status;
  gmc_pkg::mode_t      out_mode;
  gmc_pkg::cmd_t       out_cmd;
  gmc_pkg::motor_t     out_motor;
  logic                advance;

  assign advance   = in_valid && (!out_valid || res.ready);
  assign evt.ready = !in_valid || advance;
  assign cfg.ready = 1'b1;

  gmc_next u_next (
    .state      (state),
    .action     (in_action),
    .time_ms    (in_time),
    .threshold  (threshold),
    .state_next (state_next)
  );

  always_comb begin
    case (state_next.phase)
      gmc_pkg::PH_OPENING, gmc_pkg::PH_REVERSING: motor_next = gmc_pkg::MOT_OPEN;
      gmc_pkg::PH_CLOSING:                        motor_next = gmc_pkg::MOT_CLOSE;
      default:                                    motor_next = gmc_pkg::MOT_STOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      state     <= gmc_pkg::STATE_RESET;
      threshold <= gmc_pkg::THRESHOLD_RESET;
    end else begin
      if (cfg.valid) begin
        threshold <= cfg.press_limit_ms;
      end
      if (evt.ready) begin
        in_valid <= evt.valid;
      end
      if (advance) begin
        state     <= state_next;
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (evt.valid && evt.ready) begin
      in_action <= gmc_pkg::action_t'(evt.action);
      in_time   <= evt.time_ms;
    end
    if (advance) begin
      out_status <= state_next.phase;
      out_mode   <= state_next.mode;
      out_cmd    <= state_next.cmd;
      out_motor  <= motor_next;
    end
  end

  assign res.valid       = out_valid;
  assign res.gate_status = out_status;
  assign res.mode_out    = out_mode;
  assign res.command_out = out_cmd;
  assign res.motor_drive = out_motor;

endmodule

// ----- rtl/gmc_checker.sv -----
// Port-level assertions for the gate motor controller, bound to the top level.
module gmc_checker (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic [2:0] gate_status,
  input logic [1:0] mode_out,
  input logic [1:0] command_out,
  input logic [1:0] motor_drive
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(gate_status) &&
      $stable(mode_out) && $stable(command_out) && $stable(motor_drive))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  a_motor_open: assert property (@(posedge clk) disable iff (rst)
    res_valid && (gate_status == gmc_pkg::PH_OPENING || gate_status == gmc_pkg::PH_REVERSING)
      |-> motor_drive == gmc_pkg::MOT_OPEN)
    else $error("motor not opening while gate opens");

  a_motor_close: assert property (@(posedge clk) disable iff (rst)
    res_valid && gate_status != gmc_pkg::PH_OPENING &&
      gate_status != gmc_pkg::PH_REVERSING
      |-> motor_drive == (gate_status == gmc_pkg::PH_CLOSING ?
                          gmc_pkg::MOT_CLOSE : gmc_pkg::MOT_STOP))
    else $error("motor drive does not match gate status");

  a_mode_none: assert property (@(posedge clk) disable iff (rst)
    res_valid && mode_out == gmc_pkg::MD_NONE
      |-> command_out == gmc_pkg::CM_NONE || command_out == gmc_pkg::CM_STOP)
    else $error("command active with no control mode");

endmodule

bind gate_motor_controller_fsm gmc_checker u_gmc_checker (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .gate_status (res.gate_status),
  .mode_out    (res.mode_out),
  .command_out (res.command_out),
  .motor_drive (res.motor_drive)
);
